>>> hdl/slfd_pkg.sv
// ----------------------------------------------------------------------------
// slfd_pkg: shared types and constants of the sync/length frame deframer
// Holds the parse phase encoding, the result record and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package slfd_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned WordW  = 16;
	localparam int unsigned PhaseW = 3;

	localparam logic [ByteW-1:0] SyncReset   = 8'h53;
	localparam logic [WordW-1:0] HeaderBytes = 16'd2;

	// Parse phase; one code of the 3-bit space has no member
	typedef enum logic [PhaseW-1:0] {
		PH_SYNC1    = 3'd0,
		PH_SYNC2    = 3'd1,
		PH_LEN_LO   = 3'd2,
		PH_LEN_HI   = 3'd3,
		PH_PROTO_LO = 3'd4,
		PH_PROTO_HI = 3'd5,
		PH_BODY     = 3'd6
	} phase_t;

	// One result word plus its presence flag
	typedef struct packed {
		logic             valid;
		logic [WordW-1:0] protocol_id;
		logic [ByteW-1:0] body_byte;
		logic             has_body_byte;
		logic             last_of_frame;
		logic             bad_length;
	} result_t;

endpackage

`default_nettype wire

>>> hdl/slfd_parser.sv
// ----------------------------------------------------------------------------
// slfd_parser: frame header parser
// Walks sync, length and protocol fields one byte per step and produces at
// most one result per byte; holds all frame state.
// ----------------------------------------------------------------------------
`default_nettype none

module slfd_parser (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      step,
	input  wire logic [slfd_pkg::ByteW-1:0] in_byte,
	input  wire logic [slfd_pkg::ByteW-1:0] sync_byte,
	output slfd_pkg::result_t              result
);
	import slfd_pkg::*;

	phase_t           phase_q;
	phase_t           phase_d;
	logic [ByteW-1:0] len_lo_q;
	logic [WordW-1:0] proto_q;
	logic [WordW-1:0] left_q;
	logic [WordW-1:0] length_full;
	logic [WordW-1:0] left_dec;
	logic             len_short;
	logic             sync_hit;

	assign sync_hit    = (in_byte == sync_byte);
	assign length_full = {in_byte, len_lo_q};
	assign len_short   = (length_full < HeaderBytes);
	assign left_dec    = left_q - 16'd1;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_SYNC1:    phase_d = sync_hit ? PH_SYNC2 : PH_SYNC1;
			PH_SYNC2:    phase_d = sync_hit ? PH_LEN_LO : PH_SYNC1;
			PH_LEN_LO:   phase_d = PH_LEN_HI;
			PH_LEN_HI:   phase_d = len_short ? PH_SYNC1 : PH_PROTO_LO;
			PH_PROTO_LO: phase_d = PH_PROTO_HI;
			PH_PROTO_HI: phase_d = (left_q == '0) ? PH_SYNC1 : PH_BODY;
			PH_BODY:     phase_d = (left_dec == '0) ? PH_SYNC1 : PH_BODY;
			default:     phase_d = sync_hit ? PH_SYNC2 : PH_SYNC1;
		endcase
	end

	// Result for the current byte; valid marks a byte that yields a word
	always_comb begin
		result = '0;
		unique case (phase_q)
			PH_LEN_HI: begin
				if (len_short) begin
					result.valid         = 1'b1;
					result.last_of_frame = 1'b1;
					result.bad_length    = 1'b1;
				end
			end
			PH_PROTO_HI: begin
				if (left_q == '0) begin
					result.valid         = 1'b1;
					result.protocol_id   = {in_byte, proto_q[ByteW-1:0]};
					result.last_of_frame = 1'b1;
				end
			end
			PH_BODY: begin
				result.valid         = 1'b1;
				result.protocol_id   = proto_q;
				result.body_byte     = in_byte;
				result.has_body_byte = 1'b1;
				result.last_of_frame = (left_dec == '0);
			end
			default: result = '0;
		endcase
	end

	// Advance phase on each byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
		end else if (step) begin
			phase_q <= phase_d;
		end
	end

	// Capture header fields and count down the body
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_lo_q <= '0;
			proto_q  <= '0;
			left_q   <= '0;
		end else if (step) begin
			case (phase_q)
				PH_LEN_LO:   len_lo_q <= in_byte;
				PH_LEN_HI:   if (!len_short) left_q <= length_full - HeaderBytes;
				PH_PROTO_LO: proto_q <= {{(WordW-ByteW){1'b0}}, in_byte};
				PH_PROTO_HI: proto_q <= {in_byte, proto_q[ByteW-1:0]};
				PH_BODY:     left_q <= left_dec;
				default:     ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/sync_length_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_unit: byte stream frame deframer
// Finds two sync bytes, reads a little-endian length and protocol number and
// emits the body bytes tagged with the protocol number.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one raw stream byte per word. m_axis carries one result
//   per word: tdata holds protocol_id and body_byte, tlast marks the final
//   result of a frame, tuser flags has_body_byte and bad_length. Sync bytes
//   give no word; header bytes give one only for a short length or empty body.
//   cfg_valid/cfg_data write the sync byte; cfg_ready is always high. Write
//   it only while the block is idle.
//   Path: an accepted body byte is held in the input register, then parsed
//   and loaded into the result register, from which m_axis presents it.
//   Throughput: one byte per cycle while m_axis does not stall, set by the
//   parser step between the input and result registers.
//   Reset clears both registers, returns the parser to sync hunt and loads
//   the sync byte with ASCII 'S'.
//   When m_axis stalls with a result held, the input register still drains
//   bytes that give no result; s_axis_tready drops once a held byte would
//   produce a result with no room to put it.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_frame_deframer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sync byte write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,
	// raw stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	// results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [15:0] protocol_id, [23:16] body_byte
	output logic             m_axis_tlast,   // last_of_frame
	output logic [1:0]       m_axis_tuser    // [0] has_body_byte, [1] bad_length
);
	import slfd_pkg::*;

	logic [ByteW-1:0] sync_q;
	logic             in_valid_s1;
	logic [ByteW-1:0] in_byte_s1;
	logic             out_valid_s2;
	result_t          out_s2;
	result_t          res;
	logic             out_room;
	logic             step;
	logic             pending_hit;

	// Sync byte register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SyncReset;
		end else if (cfg_valid && cfg_ready) begin
			sync_q <= cfg_data;
		end
	end

	// Parse the held byte when the result slot can take it
	assign out_room      = !out_valid_s2 || m_axis_tready;
	assign pending_hit   = in_valid_s1 && res.valid;
	assign step          = in_valid_s1 && (out_room || !pending_hit);
	assign s_axis_tready = !in_valid_s1 || step;

	slfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.in_byte   (in_byte_s1),
		.sync_byte (sync_q),
		.result    (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1 <= s_axis_tdata;
		end
	end

	// Result register: load on a produced result, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (step && res.valid) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			out_s2 <= res;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {out_s2.body_byte, out_s2.protocol_id};
	assign m_axis_tlast  = out_s2.last_of_frame;
	assign m_axis_tuser  = {out_s2.bad_length, out_s2.has_body_byte};

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for sync_length_frame_deframer_unit
// Drives a scripted byte sequence, then mostly well-formed random frames
// with noise and broken sync in between, under four sync byte values.
// A local parser model predicts each result word; results are compared
// field by field as they leave the block, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb;
	import slfd_pkg::*;

	typedef struct packed {
		logic [15:0] protocol_id;
		logic [7:0]  body_byte;
		logic        has_body_byte;
		logic        last_of_frame;
		logic        bad_length;
	} frame_out_t;

	// One scripted byte; typed rows carry their own expected result word
	typedef struct packed {
		logic [7:0] in_byte;
		logic       typed;
		frame_out_t want;
	} script_row_t;

	localparam int ScriptLen = 25;
	localparam int PhaseItems = 370;
	localparam int NumSettings = 4;
	localparam logic [27:0] PREDICT = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'h00;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;   // [15:0] protocol_id, [23:16] body_byte
	logic        m_axis_tlast;   // last_of_frame
	logic [1:0]  m_axis_tuser;   // [0] has_body_byte, [1] bad_length

	// Parser model state
	phase_t      ph = PH_SYNC1;
	logic [7:0]  sync_value = SyncReset;
	logic [15:0] len_field = '0;
	logic [15:0] proto_field = '0;
	logic [15:0] body_left = '0;

	frame_out_t  want_results [$];
	int          errors = 0;
	int          bytes_sent = 0;
	int          results_seen = 0;
	int          frames_sent = 0;
	int          sink_hold = 0;
	bit          burst_mode = 1'b0;

	// Sync hunt, broken sync, short lengths, empty body, two-byte body
	script_row_t script [0:ScriptLen-1] = '{
		{8'h00, PREDICT},
		{8'h53, PREDICT},
		{8'h00, PREDICT},
		{8'h53, PREDICT},
		{8'h53, PREDICT},
		{8'h01, PREDICT},
		{8'h00, 1'b1, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1},
		{8'h53, PREDICT},
		{8'h53, PREDICT},
		{8'h00, PREDICT},
		{8'h00, 1'b1, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1},
		{8'h53, PREDICT},
		{8'h53, PREDICT},
		{8'h02, PREDICT},
		{8'h00, PREDICT},
		{8'hFF, PREDICT},
		{8'hFF, 1'b1, 16'hFFFF, 8'h00, 1'b0, 1'b1, 1'b0},
		{8'h53, PREDICT},
		{8'h53, PREDICT},
		{8'h04, PREDICT},
		{8'h00, PREDICT},
		{8'h00, PREDICT},
		{8'h00, PREDICT},
		{8'hFF, 1'b1, 16'h0000, 8'hFF, 1'b1, 1'b0, 1'b0},
		{8'h00, 1'b1, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b0}
	};

	sync_length_frame_deframer_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Advance the parser by one byte; return 1 when it yields a result word
	function automatic bit deframe_byte(input logic [7:0] b, output frame_out_t r);
		bit produced;
		produced = 1'b0;
		r = '0;
		case (ph)
		PH_SYNC2: ph = (b == sync_value) ? PH_LEN_LO : PH_SYNC1;
		PH_LEN_LO: begin
			len_field = {8'h00, b};
			ph = PH_LEN_HI;
		end
		PH_LEN_HI: begin
			len_field[15:8] = b;
			if (len_field < HeaderBytes) begin
				r.last_of_frame = 1'b1;
				r.bad_length = 1'b1;
				produced = 1'b1;
				ph = PH_SYNC1;
			end else begin
				body_left = len_field - HeaderBytes;
				ph = PH_PROTO_LO;
			end
		end
		PH_PROTO_LO: begin
			proto_field = {8'h00, b};
			ph = PH_PROTO_HI;
		end
		PH_PROTO_HI: begin
			proto_field[15:8] = b;
			if (body_left == 16'd0) begin
				r.protocol_id = proto_field;
				r.last_of_frame = 1'b1;
				produced = 1'b1;
				ph = PH_SYNC1;
			end else begin
				ph = PH_BODY;
			end
		end
		PH_BODY: begin
			body_left = body_left - 16'd1;
			r.protocol_id = proto_field;
			r.body_byte = b;
			r.has_body_byte = 1'b1;
			r.last_of_frame = (body_left == 16'd0);
			produced = 1'b1;
			if (body_left == 16'd0)
				ph = PH_SYNC1;
		end
		default: ph = (b == sync_value) ? PH_SYNC2 : PH_SYNC1;
		endcase
		return produced;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	// Offer one stream word, wait for the handshake, then log its result
	task automatic push_byte(input logic [7:0] b, input bit typed, input frame_out_t want);
		int gap;
		frame_out_t pred;
		bit produced;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		produced = deframe_byte(b, pred);
		if (typed)
			want_results.insert(want_results.size(), want);
		else if (produced)
			want_results.insert(want_results.size(), pred);
		bytes_sent++;
	endtask

	// Any byte except the sync value, so frames stay aligned
	task automatic send_noise();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == sync_value)
			b = b ^ 8'h01;
		push_byte(b, 1'b0, '0);
	endtask

	task automatic send_frame();
		int r;
		int len;
		logic [15:0] proto;
		r = $urandom_range(0, 99);
		if (r < 6)
			len = $urandom_range(0, 1);
		else if (r < 12)
			len = 2;
		else if (r < 95)
			len = $urandom_range(3, 20);
		else
			len = $urandom_range(200, 300);
		proto = 16'($urandom);
		push_byte(sync_value, 1'b0, '0);
		push_byte(sync_value, 1'b0, '0);
		push_byte(len[7:0], 1'b0, '0);
		push_byte(len[15:8], 1'b0, '0);
		if (len >= 2) begin
			push_byte(proto[7:0], 1'b0, '0);
			push_byte(proto[15:8], 1'b0, '0);
			repeat (len - 2)
				push_byte(8'($urandom), 1'b0, '0);
		end
		frames_sent++;
	endtask

	// Hold the stream idle until every result word is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (want_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_sync(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sync_value = v;
	endtask

	task automatic check_result();
		frame_out_t want;
		results_seen++;
		if (want_results.size() == 0) begin
			report_mismatch("unexpected result word", int'(m_axis_tdata), 0);
		end else begin
			want = want_results.pop_front();
			if (m_axis_tdata[15:0] !== want.protocol_id)
				report_mismatch("protocol_id", int'(m_axis_tdata[15:0]),
					int'(want.protocol_id));
			if (m_axis_tdata[23:16] !== want.body_byte)
				report_mismatch("body_byte", int'(m_axis_tdata[23:16]),
					int'(want.body_byte));
			if (m_axis_tuser[0] !== want.has_body_byte)
				report_mismatch("has_body_byte", int'(m_axis_tuser[0]),
					int'(want.has_body_byte));
			if (m_axis_tlast !== want.last_of_frame)
				report_mismatch("last_of_frame", int'(m_axis_tlast),
					int'(want.last_of_frame));
			if (m_axis_tuser[1] !== want.bad_length)
				report_mismatch("bad_length", int'(m_axis_tuser[1]),
					int'(want.bad_length));
		end
	endtask

	// Result side: check each accepted word, stall at random
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result();
		if (sink_hold > 0) begin
			sink_hold--;
			m_axis_tready <= 1'b0;
		end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
			sink_hold = pick_gap();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		logic [7:0] sync_plan [0:NumSettings-1];
		int phase_end;
		sync_plan[0] = 8'h00;
		sync_plan[1] = 8'hFF;
		sync_plan[2] = 8'($urandom);
		sync_plan[3] = SyncReset;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Scripted part under the reset sync value
		for (int i = 0; i < ScriptLen; i++)
			push_byte(script[i].in_byte, script[i].typed, script[i].want);

		// Random frames under each sync value
		for (int k = 0; k < NumSettings; k++) begin
			drain();
			write_sync(sync_plan[k]);
			phase_end = bytes_sent + PhaseItems;
			while (bytes_sent < phase_end) begin
				if ($urandom_range(0, 15) == 0)
					burst_mode = !burst_mode;
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 4)) send_noise();
				if ($urandom_range(0, 9) == 0) begin
					push_byte(sync_value, 1'b0, '0);
					send_noise();
				end
				send_frame();
			end
		end
		burst_mode = 1'b0;
		drain();
		repeat (8) @(posedge clk);

		$display("Sent %0d stream bytes in %0d random frames over %0d sync values",
			bytes_sent, frames_sent, NumSettings);
		$display("Checked %0d result words, %0d mismatches", results_seen, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Stop a hung run
	initial begin
		#12_000_000;
		$display("Timed out with %0d result words outstanding", want_results.size());
		$display("Regression FAIL");
		$finish;
	end
endmodule
